@@ hdl/crw_pkg.sv @@
// shared types, codes and constants of the cylinder roughness window timer
`default_nettype none
package crw_pkg;

  // table and timestamp sizes
  localparam int MAX_CYLINDERS = 8;
  localparam int TIME_W        = 32;
  localparam int FACTOR_W      = 16;
  localparam int PROD_W        = TIME_W + FACTOR_W;
  localparam int ITER_W        = $clog2(PROD_W + 1);
  localparam int CNT_W         = 5;

  // field widths
  localparam int MODE_W   = 2;
  localparam int CYL_W    = 3;
  localparam int POS_W    = 14;
  localparam int RANGE_W  = 13;
  localparam int ACTIVE_W = 4;
  localparam int ROUGH_W  = 16;
  localparam int PHASE_W  = 2;

  // stream and config port widths
  localparam int S_TDATA_W = 96;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HALF_RANGE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CYLINDERS  = 2'd1;

  // crank mode and sync kind codes
  localparam logic [MODE_W-1:0] KIND_NONE     = 2'd0;
  localparam logic [MODE_W-1:0] KIND_UNPHASED = 2'd1;
  localparam logic [MODE_W-1:0] KIND_PHASED   = 2'd2;

  // per cylinder phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE  = 2'd0;
  localparam logic [PHASE_W-1:0] PH_ARMED = 2'd1;
  localparam logic [PHASE_W-1:0] PH_START = 2'd2;
  localparam logic [PHASE_W-1:0] PH_TDC   = 2'd3;

  // roughness scale: -100 .. +100 percent in 1/256 units
  localparam logic [FACTOR_W-1:0] ROUGH_SPAN   = 16'd51200;
  localparam logic [ROUGH_W-1:0]  ROUGH_OFFSET = 16'd25600;
  localparam logic [ROUGH_W-1:0]  ROUGH_MAX    = 16'd25600;

  // reset values of the registers
  localparam logic [RANGE_W-1:0]  RANGE_RESET  = 13'd480;
  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 4'd4;

  // request to the multiply-divide unit: round(x * m / d)
  typedef struct packed {
    logic                start;
    logic [TIME_W-1:0]   x;
    logic [FACTOR_W-1:0] m;
    logic [TIME_W-1:0]   d;
  } md_req_t;

  // answer of the multiply-divide unit, done pulses for one cycle
  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] q;
  } md_rsp_t;

endpackage
`default_nettype wire

@@ hdl/crw_muldiv.sv @@
// shared multiply then restoring divide unit with round half up
`default_nettype none
module crw_muldiv (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire crw_pkg::md_req_t req,
  output crw_pkg::md_rsp_t     rsp
);
  import crw_pkg::*;

  typedef enum logic [3:0] {
    MD_IDLE = 4'b0001,
    MD_MUL  = 4'b0010,
    MD_DIV  = 4'b0100,
    MD_RND  = 4'b1000
  } md_state_t;

  md_state_t           state;
  logic [TIME_W-1:0]   xr;
  logic [FACTOR_W-1:0] mr;
  logic [TIME_W-1:0]   dvs;
  logic [PROD_W-1:0]   prod;
  logic [TIME_W:0]     rem;
  logic [TIME_W-1:0]   quo;
  logic [ITER_W-1:0]   cnt;
  logic [TIME_W:0]     rem_sh;
  logic                fits;
  logic                round_up;

  // one quotient bit per cycle
  assign rem_sh   = {rem[TIME_W-1:0], prod[PROD_W-1]};
  assign fits     = rem_sh >= {1'b0, dvs};
  assign round_up = {rem, 1'b0} >= {2'b00, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= MD_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      unique case (state)
        MD_IDLE: begin
          if (req.start) begin
            xr    <= req.x;
            mr    <= req.m;
            dvs   <= req.d;
            state <= MD_MUL;
          end
        end
        MD_MUL: begin
          prod  <= PROD_W'(xr) * PROD_W'(mr);
          rem   <= '0;
          quo   <= '0;
          cnt   <= '0;
          state <= MD_DIV;
        end
        MD_DIV: begin
          prod <= {prod[PROD_W-2:0], 1'b0};
          if (fits) begin
            rem <= rem_sh - {1'b0, dvs};
            quo <= {quo[TIME_W-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[TIME_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == ITER_W'(PROD_W - 1)) begin
            state <= MD_RND;
          end
        end
        MD_RND: begin
          rsp.q    <= quo + TIME_W'(round_up);
          rsp.done <= 1'b1;
          state    <= MD_IDLE;
        end
        default: begin
          state <= MD_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/cylinder_roughness_window_timer.sv @@
// top level: stream ports, config registers, cylinder tables and sequencer
//
//  channel | signals                          | direction | moves
//  --------+----------------------------------+-----------+--------------------------
//  s       | s_tvalid s_tready s_tdata s_tuser| in        | one crank update per beat
//  m       | m_tvalid m_tready m_tdata m_tuser| out       | one result per update
//  cfg     | cfg_valid cfg_ready cfg_index    | in        | one register write per beat
//          | cfg_data                         |           |
//
// an update that needs no interpolation passes the evaluate and done states after accept;
// one interpolation adds a pass through the shared multiply-divide unit and the apply
// state, the end of a window a second pass for the roughness ratio; the 48-step divide
// takes most of the time of the longest update
// s_tready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next update is taken while m_tready is low
// rst is synchronous: all cylinders not armed, times and roughness zero, sync none,
// window_half_range 480 and active_cylinders 4; no clearing pass is needed
// cfg_ready is always high; writes are meant for idle periods only
`default_nettype none
module cylinder_roughness_window_timer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata: cylinder[2:0], prev_position[16:3], cur_position[30:17],
  //          prev_time[62:31], cur_time[94:63], zero[95]
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [crw_pkg::S_TDATA_W-1:0]    s_tdata,
  // s_tuser: crank_mode[1:0]
  input  wire logic [crw_pkg::S_TUSER_W-1:0]    s_tuser,
  // m_tdata: cylinder_out[2:0], roughness[18:3], cylinder_phase[20:19], zero[23:21]
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [crw_pkg::M_TDATA_W-1:0]         m_tdata,
  // m_tuser: measure_done[0], item_ignored[1]
  output logic [crw_pkg::M_TUSER_W-1:0]         m_tuser,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [crw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [crw_pkg::CFG_DAT_W-1:0]    cfg_data
);
  import crw_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EVAL   = 6'b000010,
    S_INTERP = 6'b000100,
    S_APPLY  = 6'b001000,
    S_ROUGH  = 6'b010000,
    S_DONE   = 6'b100000
  } seq_state_t;

  seq_state_t state;

  // configuration registers
  logic [RANGE_W-1:0]  window_half_range;
  logic [ACTIVE_W-1:0] active_cylinders;

  // per cylinder tables and sync kind
  logic [MODE_W-1:0]         sync_kind;
  logic [PHASE_W-1:0]        phase_tab [MAX_CYLINDERS];
  logic [TIME_W-1:0]         start_tab [MAX_CYLINDERS];
  logic [TIME_W-1:0]         tdc_tab   [MAX_CYLINDERS];
  logic signed [ROUGH_W-1:0] rough_tab [MAX_CYLINDERS];

  // the update being worked on
  logic [MODE_W-1:0]       it_mode;
  logic [CYL_W-1:0]        it_cyl;
  logic signed [POS_W-1:0] it_p0;
  logic signed [POS_W-1:0] it_p1;
  logic [TIME_W-1:0]       it_t0;
  logic [TIME_W-1:0]       it_t1;
  logic                    done_flag;
  logic                    ign_flag;
  logic                    interp_neg;
  logic [TIME_W-1:0]       t_interp;

  // output register
  logic [CYL_W-1:0]   out_cyl;
  logic [ROUGH_W-1:0] out_rough;
  logic [PHASE_W-1:0] out_phase;
  logic               out_done;
  logic               out_ign;

  md_req_t md_req;
  md_rsp_t md_rsp;

  crw_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // decode of the held update
  logic [MODE_W-1:0]          kind;
  logic                       mode_bad;
  logic                       cyl_off;
  logic                       cyl_in_tab;
  logic [PHASE_W-1:0]         cur_phase;
  logic signed [RANGE_W+1:0]  rs;
  logic signed [RANGE_W+1:0]  neg_rs;
  logic signed [RANGE_W+1:0]  p1e;
  logic signed [RANGE_W+1:0]  target;
  logic signed [RANGE_W+2:0]  num;
  logic signed [RANGE_W+2:0]  den;
  logic [FACTOR_W-1:0]        num_abs;
  logic [FACTOR_W-1:0]        den_abs;
  logic                       arm_hit;
  logic                       start_hit;
  logic                       tdc_hit;
  logic                       tdc_over;
  logic                       end_hit;
  logic                       end_under;
  logic                       need_interp;
  logic [TIME_W-1:0]          span_a;
  logic [TIME_W-1:0]          span_b;
  logic                       shift_out;

  assign kind = (it_mode == KIND_PHASED)   ? KIND_PHASED :
                (it_mode == KIND_UNPHASED) ? KIND_UNPHASED : KIND_NONE;
  assign mode_bad   = (kind == KIND_NONE) || (kind != sync_kind);
  assign cyl_in_tab = {2'b00, it_cyl} < CNT_W'(MAX_CYLINDERS);
  assign cyl_off    = ({2'b00, it_cyl} >= {1'b0, active_cylinders}) || !cyl_in_tab;
  assign cur_phase  = phase_tab[it_cyl];

  assign rs     = $signed({2'b00, window_half_range});
  assign neg_rs = -rs;
  assign p1e    = {it_p1[POS_W-1], it_p1};

  // crossing target: -R for the window start, TDC, +R for the window end
  always_comb begin
    unique case (cur_phase)
      PH_ARMED: target = neg_rs;
      PH_START: target = '0;
      default:  target = rs;
    endcase
  end

  assign num     = {target[RANGE_W+1], target} - {{2{it_p0[POS_W-1]}}, it_p0};
  assign den     = {{2{it_p1[POS_W-1]}}, it_p1} - {{2{it_p0[POS_W-1]}}, it_p0};
  assign num_abs = num[RANGE_W+2] ? FACTOR_W'(-num) : FACTOR_W'(num);
  assign den_abs = den[RANGE_W+2] ? FACTOR_W'(-den) : FACTOR_W'(den);

  assign arm_hit   = (p1e < neg_rs) || (p1e > rs);
  assign start_hit = (p1e >= neg_rs) && (p1e <= 0);
  assign tdc_hit   = (p1e >= 0) && (p1e <= rs);
  assign tdc_over  = p1e > rs;
  assign end_hit   = p1e >= rs;
  assign end_under = p1e < neg_rs;

  assign need_interp = ((cur_phase == PH_ARMED) && start_hit) ||
                       ((cur_phase == PH_START) && tdc_hit) ||
                       ((cur_phase == PH_TDC)   && end_hit);

  // spans measured from the window start, both wrap with the timer
  assign span_a = tdc_tab[it_cyl] - start_tab[it_cyl];
  assign span_b = t_interp - start_tab[it_cyl];

  // the shared unit gets the interpolation first, then the roughness ratio
  always_comb begin
    md_req.start = 1'b0;
    md_req.x     = it_t1 - it_t0;
    md_req.m     = num_abs;
    md_req.d     = TIME_W'(den_abs);
    unique case (state)
      S_EVAL: begin
        md_req.start = !mode_bad && !cyl_off && need_interp && (den != 0);
      end
      S_APPLY: begin
        md_req.x = span_a;
        md_req.m = ROUGH_SPAN;
        md_req.d = span_b;
        md_req.start = (cur_phase == PH_TDC) && (span_b != 0) && (span_a < span_b);
      end
      default: begin
        md_req.start = 1'b0;
      end
    endcase
  end

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign shift_out = !m_tvalid || m_tready;

  assign m_tdata = {{(M_TDATA_W - CYL_W - ROUGH_W - PHASE_W){1'b0}},
                    out_phase, out_rough, out_cyl};
  assign m_tuser = {out_ign, out_done};

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_half_range <= RANGE_RESET;
      active_cylinders  <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_WINDOW_HALF_RANGE: window_half_range <= cfg_data[RANGE_W-1:0];
        REG_ACTIVE_CYLINDERS:  active_cylinders  <= cfg_data[ACTIVE_W-1:0];
        default: ;
      endcase
    end
  end

  // capture of an accepted update
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      it_mode <= s_tuser[MODE_W-1:0];
      it_cyl  <= s_tdata[2:0];
      it_p0   <= s_tdata[16:3];
      it_p1   <= s_tdata[30:17];
      it_t0   <= s_tdata[62:31];
      it_t1   <= s_tdata[94:63];
    end
  end

  // sequencer, tables and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sync_kind <= KIND_NONE;
      m_tvalid  <= 1'b0;
      done_flag <= 1'b0;
      ign_flag  <= 1'b0;
      for (int c = 0; c < MAX_CYLINDERS; c++) begin
        phase_tab[c] <= PH_IDLE;
        start_tab[c] <= '0;
        tdc_tab[c]   <= '0;
        rough_tab[c] <= '0;
      end
    end else begin
      // a taken beat leaves unless the done state loads the next one
      if (m_tvalid && m_tready && (state != S_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            done_flag <= 1'b0;
            ign_flag  <= 1'b0;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          state <= S_DONE;
          if (mode_bad) begin
            // mode lost or changed: the whole table starts over
            sync_kind <= kind;
            ign_flag  <= 1'b1;
            for (int c = 0; c < MAX_CYLINDERS; c++) begin
              phase_tab[c] <= PH_IDLE;
              start_tab[c] <= '0;
              tdc_tab[c]   <= '0;
              rough_tab[c] <= '0;
            end
          end else if (cyl_off) begin
            ign_flag <= 1'b1;
          end else if (need_interp) begin
            interp_neg <= num[RANGE_W+2] ^ den[RANGE_W+2];
            if (den == 0) begin
              // no crank movement: take the current timestamp
              t_interp <= it_t1;
              state    <= S_APPLY;
            end else begin
              state <= S_INTERP;
            end
          end else begin
            unique case (cur_phase)
              PH_IDLE: begin
                if (arm_hit) begin
                  phase_tab[it_cyl] <= PH_ARMED;
                end
              end
              PH_START: begin
                if (tdc_over) begin
                  phase_tab[it_cyl] <= PH_IDLE;
                  start_tab[it_cyl] <= '0;
                  tdc_tab[it_cyl]   <= '0;
                  rough_tab[it_cyl] <= '0;
                end
              end
              PH_TDC: begin
                if (end_under) begin
                  phase_tab[it_cyl] <= PH_IDLE;
                  start_tab[it_cyl] <= '0;
                  tdc_tab[it_cyl]   <= '0;
                  rough_tab[it_cyl] <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        S_INTERP: begin
          if (md_rsp.done) begin
            t_interp <= interp_neg ? (it_t0 - md_rsp.q) : (it_t0 + md_rsp.q);
            state    <= S_APPLY;
          end
        end
        S_APPLY: begin
          state <= S_DONE;
          unique case (cur_phase)
            PH_ARMED: begin
              start_tab[it_cyl] <= t_interp;
              phase_tab[it_cyl] <= PH_START;
            end
            PH_START: begin
              tdc_tab[it_cyl]   <= t_interp;
              phase_tab[it_cyl] <= PH_TDC;
            end
            PH_TDC: begin
              if (span_b == 0) begin
                rough_tab[it_cyl] <= '0;
                phase_tab[it_cyl] <= PH_ARMED;
                done_flag         <= 1'b1;
              end else if (span_a >= span_b) begin
                // tdc at or past the window end
                rough_tab[it_cyl] <= ROUGH_MAX;
                phase_tab[it_cyl] <= PH_ARMED;
                done_flag         <= 1'b1;
              end else begin
                state <= S_ROUGH;
              end
            end
            default: ;
          endcase
        end
        S_ROUGH: begin
          if (md_rsp.done) begin
            rough_tab[it_cyl] <= md_rsp.q[ROUGH_W-1:0] - ROUGH_OFFSET;
            phase_tab[it_cyl] <= PH_ARMED;
            done_flag         <= 1'b1;
            state             <= S_DONE;
          end
        end
        S_DONE: begin
          if (shift_out) begin
            out_cyl  <= it_cyl;
            out_done <= done_flag;
            out_ign  <= ign_flag;
            if (cyl_in_tab) begin
              out_rough <= rough_tab[it_cyl];
              out_phase <= phase_tab[it_cyl];
            end else begin
              out_rough <= '0;
              out_phase <= PH_IDLE;
            end
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/crw_checker.sv @@
// port level checks of the roughness window timer and their bind
`default_nettype none
module crw_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [crw_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [crw_pkg::M_TUSER_W-1:0] m_tuser
);
  import crw_pkg::*;

  logic signed [ROUGH_W-1:0] rough;
  assign rough = m_tdata[18:3];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result beat changed while stalled");

  // one update at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("update accepted while busy");

  // an ignored update never completes a measurement
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("measure_done and item_ignored both set");

  // a finished measurement rearms its cylinder
  a_rearm: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[20:19] == PH_ARMED)
    else $error("measurement done without rearm");

  // roughness stays within -100 .. +100 percent
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (rough >= -16'sd25600) && (rough <= 16'sd25600))
    else $error("roughness out of range");

endmodule

bind cylinder_roughness_window_timer crw_checker u_crw_checker (.*);
`default_nettype wire
